### design/brand_pkg.sv
// shared constants, types and queue entry layout for the bounded random interval block
`default_nettype none

package brand_pkg;

   // datapath width and port field width
   localparam int WORD_BITS  = 64;
   localparam int FIELD_BITS = 64;

   // split of a word into lower and upper halves for the partial products
   localparam int LO_BITS = WORD_BITS / 2;
   localparam int UP_BITS = WORD_BITS - LO_BITS;

   localparam int CSR_INDEX_BITS = 8;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int THR_CNT_BITS = $clog2(WORD_BITS);

   typedef logic [FIELD_BITS-1:0]     field_type;
   typedef logic [WORD_BITS-1:0]      word_type;
   typedef logic [WORD_BITS:0]        word_ext_type;
   typedef logic [2*WORD_BITS-1:0]    wide_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [QUEUE_PTR_BITS-1:0] queue_ptr_type;
   typedef logic [QUEUE_CNT_BITS-1:0] queue_cnt_type;
   typedef logic [THR_CNT_BITS-1:0]   thr_cnt_type;

   // register indexes
   localparam csr_index_type CSR_RANGE_LOW  = CSR_INDEX_BITS'(0);
   localparam csr_index_type CSR_RANGE_HIGH = CSR_INDEX_BITS'(1);

   // one classified word with its four partial products
   typedef struct packed {
      logic                   full_range;
      word_type               word;
      logic [2*LO_BITS-1:0]   p_ll;
      word_type               p_lu;
      word_type               p_ul;
      logic [2*UP_BITS-1:0]   p_uu;
   } work_item_type;

endpackage

`default_nettype wire

### design/brand_thresh.sv
// serial remainder unit for the rejection threshold 2^W mod span
`default_nettype none

module brand_thresh (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  brand_pkg::word_type span,
   output brand_pkg::word_type threshold,
   output logic                busy
);
   import brand_pkg::*;

   logic         busy_ff, busy_in;
   thr_cnt_type  cnt_ff, cnt_in;
   word_type     rem_ff, rem_in;
   word_type     div_ff, div_in;
   word_type     span_ff, span_in;
   word_ext_type trial;
   logic         fits;

   // one dividend bit per cycle, dividend is 2^W - span
   always_comb begin
      trial   = {rem_ff, div_ff[WORD_BITS-1]};
      fits    = trial >= {1'b0, span_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      span_in = span_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = THR_CNT_BITS'(WORD_BITS - 1);
         rem_in  = '0;
         div_in  = '0 - span;
         span_in = span;
      end else if (busy_ff) begin
         rem_in  = fits ? WORD_BITS'(trial - {1'b0, span_ff}) : trial[WORD_BITS-1:0];
         div_in  = {div_ff[WORD_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - THR_CNT_BITS'(1);
         busy_in = (cnt_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         span_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         span_ff <= span_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
   end

   assign threshold = rem_ff;
   assign busy      = busy_ff;

   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("threshold unit did not start");

   assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !start && span_ff != '0) |-> (rem_ff < span_ff))
      else $error("threshold not below span");

   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == '0) |=> !busy_ff)
      else $error("threshold unit ran past last bit");

endmodule

`default_nettype wire

### design/brand_front.sv
// front stage: takes random words, flags full range and forms partial products
`default_nettype none

module brand_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  brand_pkg::word_type      random_word,
   input  brand_pkg::word_type      span,
   input  logic                     queue_full,
   output logic                     item_valid,
   output brand_pkg::work_item_type item
);
   import brand_pkg::*;

   logic                 valid_ff, valid_in;
   work_item_type        item_ff, item_in;
   logic                 stage_free;
   logic [LO_BITS-1:0]   r_lo, n_lo;
   logic [UP_BITS-1:0]   r_up, n_up;

   always_comb begin
      r_lo = random_word[LO_BITS-1:0];
      r_up = random_word[WORD_BITS-1:LO_BITS];
      n_lo = span[LO_BITS-1:0];
      n_up = span[WORD_BITS-1:LO_BITS];
      item_in.full_range = (span == '0);
      item_in.word       = random_word;
      item_in.p_ll       = (2*LO_BITS)'(r_lo) * (2*LO_BITS)'(n_lo);
      item_in.p_lu       = WORD_BITS'(r_lo) * WORD_BITS'(n_up);
      item_in.p_ul       = WORD_BITS'(r_up) * WORD_BITS'(n_lo);
      item_in.p_uu       = (2*UP_BITS)'(r_up) * (2*UP_BITS)'(n_up);
   end

   // stage empties into the queue whenever the queue has room
   assign stage_free = !valid_ff || !queue_full;
   assign req_ready  = stage_free && enable;
   assign valid_in   = stage_free ? (req_valid && enable) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

### design/brand_queue.sv
// short register queue between front and back
`default_nettype none

module brand_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  brand_pkg::work_item_type in_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output brand_pkg::work_item_type out_item
);
   import brand_pkg::*;

   work_item_type entries_ff [QUEUE_DEPTH];
   queue_ptr_type wr_ptr_ff, wr_ptr_in;
   queue_ptr_type rd_ptr_ff, rd_ptr_in;
   queue_cnt_type count_ff, count_in;
   logic          push;

   assign full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign push  = in_valid && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_BITS'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

   assign out_item = entries_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count past depth");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QUEUE_CNT_BITS'(1)))
      else $error("queue count lost a push");

endmodule

`default_nettype wire

### design/brand_back.sv
// back pipeline: sums partial products, applies rejection and adds the interval base
`default_nettype none

module brand_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  brand_pkg::work_item_type q_item,
   output logic                     q_pop,
   input  brand_pkg::word_type      range_low,
   input  brand_pkg::word_type      threshold,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output brand_pkg::word_type      bounded_value
);
   import brand_pkg::*;

   // stage a: middle partial products summed
   logic                 a_valid_ff, a_valid_in;
   logic                 a_full_ff;
   word_type             a_word_ff;
   logic [2*LO_BITS-1:0] a_ll_ff;
   logic [2*UP_BITS-1:0] a_uu_ff;
   word_ext_type         a_mid_ff, a_mid_in;

   // stage b: full product split in halves
   logic                 b_valid_ff, b_valid_in;
   logic                 b_full_ff;
   word_type             b_word_ff;
   word_type             b_lo_ff;
   word_type             b_hi_ff;
   wide_type             product_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   word_type             out_value_ff, out_value_in;

   logic                 out_adv, b_en, a_en, keep;

   always_comb begin
      out_adv = !out_valid_ff || rsp_ready;
      b_en    = !b_valid_ff || out_adv;
      a_en    = !a_valid_ff || b_en;
      q_pop   = !q_empty && a_en;

      a_mid_in   = (WORD_BITS + 1)'(q_item.p_lu) + (WORD_BITS + 1)'(q_item.p_ul);
      product_in = {a_uu_ff, a_ll_ff} + (wide_type'(a_mid_ff) << LO_BITS);

      keep         = b_full_ff || (b_lo_ff >= threshold);
      out_value_in = (b_full_ff ? b_word_ff : b_hi_ff) + range_low;

      a_valid_in   = a_en ? !q_empty : a_valid_ff;
      b_valid_in   = b_en ? a_valid_ff : b_valid_ff;
      out_valid_in = out_adv ? (b_valid_ff && keep) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_full_ff <= q_item.full_range;
         a_word_ff <= q_item.word;
         a_ll_ff   <= q_item.p_ll;
         a_uu_ff   <= q_item.p_uu;
         a_mid_ff  <= a_mid_in;
      end
      if (b_en && a_valid_ff) begin
         b_full_ff <= a_full_ff;
         b_word_ff <= a_word_ff;
         b_lo_ff   <= product_in[WORD_BITS-1:0];
         b_hi_ff   <= product_in[2*WORD_BITS-1:WORD_BITS];
      end
      if (out_adv && b_valid_ff && keep) begin
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign bounded_value = out_value_ff;

endmodule

`default_nettype wire

### design/bounded_random_interval.sv
// top level of the bounded random interval mapper
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------
//  csr      | in        | csr_valid / csr_ready  | csr_index, csr_data
//  req      | in        | req_valid / req_ready  | req_random_word
//  rsp      | out       | rsp_valid / rsp_ready  | rsp_bounded_value
//
// one random word is taken per cycle while the threshold is current and the queue has room; a kept
// word reaches rsp through the front register, queue, two product stages and output register
// after each write to a known register index the threshold unit runs, one remainder bit a cycle,
// behind a registered start; req_ready is low during that time
// reset leaves the full-range interval set, so no threshold pass follows reset
// the queue lets the front keep taking words while rsp is stalled, until it fills
// rejected words leave the pipeline without a transaction on rsp
`default_nettype none

module bounded_random_interval (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  brand_pkg::csr_index_type csr_index,
   input  brand_pkg::field_type     csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  brand_pkg::field_type     req_random_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output brand_pkg::field_type     rsp_bounded_value
);
   import brand_pkg::*;

   // interval registers
   word_type      range_low_ff, range_low_in;
   word_type      range_high_ff, range_high_in;
   logic          thr_start_ff, thr_start_in;

   word_type      span;
   word_type      threshold;
   logic          thr_busy;
   logic          front_enable;

   // front to queue
   logic          front_valid;
   work_item_type front_item;
   logic          queue_full;

   // queue to back
   logic          queue_empty;
   logic          queue_pop;
   work_item_type queue_item;

   word_type      value;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // decode writes; only known indexes restart the threshold
   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      thr_start_in  = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RANGE_LOW: begin
               range_low_in = csr_data[WORD_BITS-1:0];
               thr_start_in = 1'b1;
            end
            CSR_RANGE_HIGH: begin
               range_high_in = csr_data[WORD_BITS-1:0];
               thr_start_in  = 1'b1;
            end
            default: begin
               thr_start_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= '1;
         thr_start_ff  <= 1'b0;
      end else begin
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         thr_start_ff  <= thr_start_in;
      end
   end

   // span wraps to zero for the full range
   assign span = range_high_ff - range_low_ff + WORD_BITS'(1);

   // hold off words while the threshold is stale
   assign front_enable = !thr_busy && !thr_start_ff;

   brand_thresh u_thresh (
      .clock     (clock),
      .reset     (reset),
      .start     (thr_start_ff),
      .span      (span),
      .threshold (threshold),
      .busy      (thr_busy)
   );

   brand_front u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (front_enable),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .random_word (req_random_word[WORD_BITS-1:0]),
      .span        (span),
      .queue_full  (queue_full),
      .item_valid  (front_valid),
      .item        (front_item)
   );

   brand_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (front_valid),
      .in_item  (front_item),
      .full     (queue_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .out_item (queue_item)
   );

   brand_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (queue_empty),
      .q_item        (queue_item),
      .q_pop         (queue_pop),
      .range_low     (range_low_ff),
      .threshold     (threshold),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .bounded_value (value)
   );

   // result is sized to the port field, which is as wide as the word
   assign rsp_bounded_value = FIELD_BITS'(value);

endmodule

`default_nettype wire

### sim/tb_top.sv
// self-checking testbench for the bounded random interval mapper
`timescale 1ns / 100ps

module tb_top;
   import brand_pkg::*;

   // register indexes that the block has to ignore
   localparam csr_index_type CSR_FIRST_UNUSED = csr_index_type'(2);
   localparam csr_index_type CSR_LAST_UNUSED  = '1;

   localparam int DRAIN_CYCLES   = 12;     // pipeline depth plus margin
   localparam int HOLD_CYCLES    = 400;    // long rsp hold-off
   localparam int RANDOM_PHASES  = 12;
   localparam int WORDS_PER_PHASE = 137;
   localparam int CYCLE_LIMIT    = 100000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = '0;
   field_type     csr_data = '0;
   logic          req_valid = 1'b0;
   logic          req_ready;
   field_type     req_random_word = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   field_type     rsp_bounded_value;

   bounded_random_interval dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_random_word   (req_random_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bounded_value (rsp_bounded_value)
   );

   // words waiting to be offered, and mapped values waiting to come out
   word_type pending_words[$];
   word_type expected_values[$];

   // predictor copy of the interval registers and the threshold cache
   word_type range_lo  = '0;
   word_type range_hi  = '1;
   word_type thr_cache = '0;
   bit       thr_valid = 1'b0;

   // idling knobs, in percent of cycles
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_arm = 1'b0;
   bit  req_accepted = 1'b0;
   int  error_count = 0;
   int  cycle_count = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // register write as seen by the mapper; other indexes fall through
   function automatic void apply_range_write(input csr_index_type index, input word_type data);
      case (index)
         CSR_RANGE_LOW: begin
            range_lo  = data;
            thr_valid = 1'b0;
         end
         CSR_RANGE_HIGH: begin
            range_hi  = data;
            thr_valid = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // returns 1 when the word is kept, with the mapped value in value
   function automatic bit map_word(input word_type word, output word_type value);
      word_type span_n;
      wide_type product;
      span_n = range_hi - range_lo + 1'b1;
      // full range: span wrapped to zero, word passes with an offset
      if (span_n == '0) begin
         value = word + range_lo;
         return 1'b1;
      end
      // threshold is 2^64 mod span, taken as (2^64 - span) mod span
      if (!thr_valid) begin
         thr_cache = (~span_n + 1'b1) % span_n;
         thr_valid = 1'b1;
      end
      product = wide_type'(word) * wide_type'(span_n);
      value   = product[2*WORD_BITS-1:WORD_BITS] + range_lo;
      return product[WORD_BITS-1:0] >= thr_cache;
   endfunction

   // random word, biased now and then toward the ends of the range
   function automatic word_type pick_word();
      case ($urandom_range(15, 0))
         0:       return '0;
         1:       return '1;
         2:       return word_type'($urandom_range(7, 0));
         3:       return ~word_type'($urandom_range(7, 0));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // interval span by class: small, medium, large, full, reject-heavy, power of two
   function automatic word_type pick_span(input int kind);
      case (kind)
         0:       return word_type'($urandom_range(1000, 1));
         1:       return {32'b0, $urandom} | 64'd1;
         2:       return {$urandom, $urandom};
         3:       return '0;
         4:       return {1'b1, 63'b0} + word_type'($urandom_range(1000, 1));
         default: return word_type'(1) << $urandom_range(WORD_BITS - 1, 0);
      endcase
   endfunction

   // req side: predict every word that goes through a transaction
   always @(posedge clock) begin
      word_type value;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            if (map_word(req_random_word, value))
               expected_values.push_back(value);
         end
      end
   end

   // rsp side: compare each transaction with the oldest prediction
   always @(posedge clock) begin
      word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_values.size() == 0) begin
            $display("%0t: unexpected bounded_value %h, nothing expected", $time,
                     rsp_bounded_value);
            error_count++;
         end else begin
            want = expected_values.pop_front();
            if (rsp_bounded_value !== want) begin
               $display("%0t: bounded_value mismatch, expected %h, got %h", $time, want,
                        rsp_bounded_value);
               error_count++;
            end
         end
      end
   end

   // driver: a new word goes out only once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid       <= 1'b1;
            req_random_word <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off once armed
   always @(negedge clock) begin
      int  hold_left;
      bit  hold_done;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one register write through the csr channel
   task automatic write_reg(input csr_index_type index, input word_type data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      apply_range_write(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every word went in and every kept value came out,
   // then give rejected words time to leave the pipeline
   task automatic wait_drained(input int tail);
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_values.size() != 0);
      repeat (tail) @(posedge clock);
   endtask

   task automatic set_range(input word_type low_bound, input word_type high_bound);
      write_reg(CSR_RANGE_LOW, low_bound);
      write_reg(CSR_RANGE_HIGH, high_bound);
   endtask

   initial begin
      word_type low_bound;
      word_type span;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first idling mode: sender idles a third of the time, receiver most of it
      send_idle_pct = 34;
      recv_idle_pct = 77;

      // full range straight out of reset, word extremes and bit patterns
      pending_words.push_back('0);
      pending_words.push_back('1);
      pending_words.push_back(64'd1);
      pending_words.push_back(64'h8000_0000_0000_0000);
      pending_words.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      pending_words.push_back(64'h5555_5555_5555_5555);
      wait_drained(DRAIN_CYCLES);

      // full range with an offset, sum wraps past the top
      set_range(64'd5, 64'd4);
      pending_words.push_back('1);
      pending_words.push_back(64'hFFFF_FFFF_FFFF_FFFB);
      wait_drained(DRAIN_CYCLES);

      // span just above half the word range, about half the words rejected
      set_range('0, 64'h8000_0000_0000_0000);
      pending_words.push_back('0);
      pending_words.push_back(64'd1);
      pending_words.push_back('1);
      pending_words.push_back(64'd2);
      wait_drained(DRAIN_CYCLES);

      // single-value interval at the top
      set_range('1, '1);
      pending_words.push_back('0);
      pending_words.push_back('1);
      wait_drained(DRAIN_CYCLES);

      // inverted interval, span wraps to three
      set_range('1, 64'd1);
      pending_words.push_back('0);
      pending_words.push_back(64'd1);
      pending_words.push_back('1);
      wait_drained(DRAIN_CYCLES);

      // single value at zero, then writes to unused indexes change nothing
      set_range('0, '0);
      write_reg(CSR_FIRST_UNUSED, '1);
      write_reg(CSR_LAST_UNUSED, 64'h0123_4567_89AB_CDEF);
      pending_words.push_back({$urandom, $urandom});
      pending_words.push_back('1);
      wait_drained(DRAIN_CYCLES);

      // widest span short of full range, only word zero is rejected
      set_range('0, 64'hFFFF_FFFF_FFFF_FFFE);
      pending_words.push_back('0);
      pending_words.push_back('1);
      wait_drained(DRAIN_CYCLES);

      // random phases, each with its own interval
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES / 3) begin
            // roles swapped: receiver mostly ready, sender mostly idle
            send_idle_pct = 77;
            recv_idle_pct = 34;
         end else if (phase == 2 * RANDOM_PHASES / 3) begin
            // no idling at all; the long rsp hold-off fills the block
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         span = pick_span(phase % 6);
         case ($urandom_range(3, 0))
            0:       low_bound = '0;
            1:       low_bound = '1;
            default: low_bound = {$urandom, $urandom};
         endcase
         set_range(low_bound, low_bound + span - 1'b1);
         if (phase == 2 * RANDOM_PHASES / 3)
            hold_arm = 1'b1;
         for (int i = 0; i < WORDS_PER_PHASE; i++)
            pending_words.push_back(pick_word());
         wait_drained(DRAIN_CYCLES);
      end

      wait_drained(2 * DRAIN_CYCLES);
      if (error_count == 0 && expected_values.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
